// ===== hw/rtl/pcsd_pkg.sv =====
// Package for the prefix code symbol decoder.
// Holds sizes, item structs, table entry type and sequencer states; no dependencies.
package pcsd_pkg;

  localparam int NUM_SYMBOLS  = 256;
  localparam int MAX_CODE_LEN = 16;
  localparam int SYM_W        = $clog2(NUM_SYMBOLS);
  localparam int SCAN_W       = $clog2(NUM_SYMBOLS + 1);
  localparam int LEN_W        = 5;
  localparam int CODE_W       = 16;
  localparam int BYTE_BITS    = 8;
  localparam int LEFT_W       = 4;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_DATA = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  symbol_index;
    logic [15:0] code_bits;
    logic [4:0]  code_length;
    logic [7:0]  data_byte;
    logic        block_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] decoded_symbol;
    logic       code_error;
    logic       last_of_byte;
  } out_item_t;

  typedef struct packed {
    logic [MAX_CODE_LEN-1:0] bits;
    logic [LEN_W-1:0]        len;
  } entry_t;

  typedef struct packed {
    logic             wr_en;
    logic [SYM_W-1:0] wr_addr;
    entry_t           wr_data;
  } tbl_wr_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SHIFT = 5'b00010,
    S_SCAN  = 5'b00100,
    S_POST  = 5'b01000,
    S_FLUSH = 5'b10000
  } state_t;

endpackage

// ===== hw/rtl/pcsd_table.sv =====
// Code table: one memory of {code bits, length} plus a valid bit per entry.
// Depends on pcsd_pkg. Read data is registered; an unwritten entry reads as no code.
module pcsd_table (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pcsd_pkg::tbl_wr_t     wr,
  input  logic                  rd_en,
  input  logic [pcsd_pkg::SYM_W-1:0] rd_addr,
  output pcsd_pkg::entry_t      rd_data
);
  import pcsd_pkg::*;

  entry_t                 mem [NUM_SYMBOLS];
  logic [NUM_SYMBOLS-1:0] valid_r;
  entry_t                 rd_data_r;
  logic                   rd_valid_r;

  always_ff @(posedge clk) begin
    if (wr.wr_en) begin
      mem[wr.wr_addr] <= wr.wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr.wr_en) begin
        valid_r[wr.wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_r <= valid_r[rd_addr];
      end
    end
  end

  always_comb begin
    rd_data = rd_data_r;
    if (!rd_valid_r) begin
      rd_data = '0;
    end
  end

endmodule

// ===== hw/rtl/pcsd_core.sv =====
// Bit-serial decode sequencer: shifts one code bit at a time into the accumulator
// and scans the code table per bit. Depends on pcsd_pkg.
module pcsd_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [7:0]                 start_byte,
  input  logic                       start_blk,
  output logic                       busy,
  output logic                       rd_en,
  output logic [pcsd_pkg::SYM_W-1:0] rd_addr,
  input  pcsd_pkg::entry_t           rd_data,
  input  logic                       out_free,
  output logic                       push,
  output pcsd_pkg::out_item_t        push_item
);
  import pcsd_pkg::*;

  state_t                 state_r, state_nxt;
  logic [CODE_W-1:0]      acc_r, acc_nxt;
  logic [LEN_W-1:0]       cnt_r, cnt_nxt;
  logic [BYTE_BITS-1:0]   byte_r, byte_nxt;
  logic [LEFT_W-1:0]      left_r, left_nxt;
  logic                   blk_r, blk_nxt;
  logic [SCAN_W-1:0]      idx_r, idx_nxt;
  logic                   cmp_vld_r, cmp_vld_nxt;
  logic [SYM_W-1:0]       cmp_idx_r, cmp_idx_nxt;
  logic                   new_vld_r, new_vld_nxt;
  out_item_t              new_r, new_nxt;
  logic                   pend_vld_r, pend_vld_nxt;
  out_item_t              pend_r, pend_nxt;
  logic                   hit;
  logic                   new_done;

  assign busy    = (state_r != S_IDLE);
  assign rd_en   = (state_r == S_SCAN) && (idx_r < SCAN_W'(NUM_SYMBOLS));
  assign rd_addr = idx_r[SYM_W-1:0];

  assign hit = cmp_vld_r && (rd_data.len != '0) && (rd_data.len == cnt_r) &&
               (rd_data.bits == acc_r);

  assign new_done = !new_vld_r || !pend_vld_r || out_free;

  always_comb begin
    state_nxt    = state_r;
    acc_nxt      = acc_r;
    cnt_nxt      = cnt_r;
    byte_nxt     = byte_r;
    left_nxt     = left_r;
    blk_nxt      = blk_r;
    idx_nxt      = idx_r;
    cmp_vld_nxt  = rd_en;
    cmp_idx_nxt  = idx_r[SYM_W-1:0];
    new_vld_nxt  = new_vld_r;
    new_nxt      = new_r;
    pend_vld_nxt = pend_vld_r;
    pend_nxt     = pend_r;
    push         = 1'b0;
    push_item    = pend_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          byte_nxt  = start_byte;
          blk_nxt   = start_blk;
          left_nxt  = LEFT_W'(BYTE_BITS);
          state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: begin
        // advance one code bit, MSB first
        acc_nxt   = {acc_r[CODE_W-2:0], byte_r[BYTE_BITS-1]};
        cnt_nxt   = cnt_r + LEN_W'(1);
        byte_nxt  = {byte_r[BYTE_BITS-2:0], 1'b0};
        left_nxt  = left_r - LEFT_W'(1);
        idx_nxt   = '0;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        idx_nxt = idx_r + SCAN_W'(1);
        if (hit) begin
          new_vld_nxt = 1'b1;
          new_nxt     = '{decoded_symbol: 8'(cmp_idx_r), code_error: 1'b0,
                          last_of_byte: 1'b0};
          acc_nxt     = '0;
          cnt_nxt     = '0;
          state_nxt   = S_POST;
        end else if (idx_r == SCAN_W'(NUM_SYMBOLS)) begin
          if (cnt_r == LEN_W'(MAX_CODE_LEN)) begin
            new_vld_nxt = 1'b1;
            new_nxt     = '{decoded_symbol: 8'd0, code_error: 1'b1, last_of_byte: 1'b0};
            acc_nxt     = '0;
            cnt_nxt     = '0;
          end
          state_nxt = S_POST;
        end
      end
      S_POST: begin
        // hold the newest result back until we know whether it ends the byte
        if (new_vld_r && pend_vld_r && out_free) begin
          push = 1'b1;
        end
        if (new_vld_r && new_done) begin
          pend_vld_nxt = 1'b1;
          pend_nxt     = new_r;
          new_vld_nxt  = 1'b0;
        end
        if (new_done) begin
          state_nxt = (left_r != '0) ? S_SHIFT : S_FLUSH;
        end
      end
      S_FLUSH: begin
        push_item.last_of_byte = 1'b1;
        if (!pend_vld_r || out_free) begin
          push         = pend_vld_r;
          pend_vld_nxt = 1'b0;
          if (blk_r) begin
            acc_nxt = '0;
            cnt_nxt = '0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      acc_r      <= '0;
      cnt_r      <= '0;
      cmp_vld_r  <= 1'b0;
      new_vld_r  <= 1'b0;
      pend_vld_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      acc_r      <= acc_nxt;
      cnt_r      <= cnt_nxt;
      cmp_vld_r  <= cmp_vld_nxt;
      new_vld_r  <= new_vld_nxt;
      pend_vld_r <= pend_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r    <= byte_nxt;
    left_r    <= left_nxt;
    blk_r     <= blk_nxt;
    idx_r     <= idx_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    new_r     <= new_nxt;
    pend_r    <= pend_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= LEN_W'(MAX_CODE_LEN))
    else $error("accumulated count above code length limit");

  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> out_free)
    else $error("result pushed into a full output register");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (!pend_vld_r && !new_vld_r))
    else $error("pending result left behind after a byte");

  a_push_pend: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> pend_vld_r)
    else $error("push without a held result");

endmodule

// ===== hw/rtl/prefix_code_symbol_decoder_top.sv =====
// Top level of the prefix code symbol decoder: input handshake, table writes,
// output register. Depends on pcsd_pkg, pcsd_table and pcsd_core.
//
// Usage: the in_ channel carries one item per beat. A load beat (cmd 0) writes
// one code table entry. A data beat (cmd 1) brings a byte that is decoded one
// bit at a time, MSB first; each bit is shifted into the accumulator, then the
// code table is scanned through its single read port, and then the result is
// settled. The per-bit table scan stops at the first matching symbol.
// in_stall is high while a byte is being decoded; one item is worked on at a time.
// Results leave through the out_ channel from a one-entry output register, up
// to eight per byte; the last result of a byte has last_of_byte set. While
// out_stall is high and the output register is full, the sequencer holds
// before its next push. Reset clears the table (every entry reads as no code),
// the bit accumulator and the output register; loads may follow at once.
module prefix_code_symbol_decoder_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  pcsd_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output pcsd_pkg::out_item_t out_item
);
  import pcsd_pkg::*;

  logic                 in_acc;
  logic                 busy;
  tbl_wr_t              wr;
  logic                 rd_en;
  logic [SYM_W-1:0]     rd_addr;
  entry_t               rd_data;
  logic                 out_free;
  logic                 push;
  out_item_t            push_item;
  logic                 out_vld_r;
  out_item_t            out_item_r;
  logic [LEN_W-1:0]     wr_len;
  logic [MAX_CODE_LEN:0] wr_mask;

  assign in_stall = busy;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    wr_len = in_item.code_length;
    if (in_item.code_length > LEN_W'(MAX_CODE_LEN)) begin
      wr_len = '0;
    end
    wr_mask            = (MAX_CODE_LEN+1)'(1) << wr_len;
    wr_mask            = wr_mask - (MAX_CODE_LEN+1)'(1);
    wr.wr_en           = in_acc && (in_item.cmd == CMD_LOAD) &&
                         (9'(in_item.symbol_index) < 9'(NUM_SYMBOLS));
    wr.wr_addr         = in_item.symbol_index[SYM_W-1:0];
    wr.wr_data.len     = wr_len;
    wr.wr_data.bits    = in_item.code_bits[MAX_CODE_LEN-1:0] & wr_mask[MAX_CODE_LEN-1:0];
  end

  pcsd_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (wr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  pcsd_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (in_acc && (in_item.cmd == CMD_DATA)),
    .start_byte (in_item.data_byte),
    .start_blk  (in_item.block_end),
    .busy       (busy),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .out_free   (out_free),
    .push       (push),
    .push_item  (push_item)
  );

  assign out_free  = !out_vld_r || !out_stall;
  assign out_valid = out_vld_r;
  assign out_item  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (push && out_free) begin
      out_item_r <= push_item;
    end
  end

endmodule

// ===== tb/sv/prefix_code_symbol_decoder_top_tb.sv =====
`timescale 1ns / 1ps
// Testbench for prefix_code_symbol_decoder_top: directed table, then random code tables
// and streams, each result checked against an in-bench decoder. Depends on pcsd_pkg.
module prefix_code_symbol_decoder_top_tb;
  import pcsd_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  prefix_code_symbol_decoder_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  // decoder state mirrored in the bench
  logic [15:0] tbl_bits [NUM_SYMBOLS];
  logic [4:0]  tbl_len  [NUM_SYMBOLS];
  logic [15:0] acc_bits;
  int          acc_cnt;
  out_item_t   pending_syms [$];

  int errors;
  int n_sent;
  int n_got;
  int n_err_results;
  int send_idle_pct;
  int recv_idle_pct;
  bit hold_recv;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("prefix_code_symbol_decoder_top_tb: FAIL");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d want %0d (result %0d)", what, got, want, n_got);
    errors++;
  endtask

  // Apply one accepted beat to the bench decoder and queue its symbols.
  task automatic decode_beat(input in_item_t it);
    out_item_t r;
    int        n;
    int        hit;
    logic [4:0] l;
    n = 0;
    if (it.cmd == CMD_LOAD) begin
      l = (it.code_length > MAX_CODE_LEN) ? 5'd0 : it.code_length;
      tbl_len[it.symbol_index]  = l;
      tbl_bits[it.symbol_index] = (l == 0) ? 16'h0 :
                                  it.code_bits & 16'((32'h1 << l) - 1);
    end else begin
      for (int b = 7; b >= 0; b--) begin
        acc_bits = {acc_bits[14:0], it.data_byte[b]};
        acc_cnt++;
        hit = -1;
        for (int s = 0; s < NUM_SYMBOLS; s++)
          if (hit < 0 && tbl_len[s] != 0 && tbl_len[s] == acc_cnt && tbl_bits[s] == acc_bits)
            hit = s;
        if (hit >= 0 || acc_cnt >= MAX_CODE_LEN) begin
          r.decoded_symbol = (hit >= 0) ? 8'(hit) : 8'd0;
          r.code_error     = (hit < 0);
          r.last_of_byte   = 1'b0;
          pending_syms.push_back(r);
          n++;
          acc_bits = '0;
          acc_cnt  = 0;
        end
      end
      if (n > 0) pending_syms[$].last_of_byte = 1'b1;
      if (it.block_end) begin
        acc_bits = '0;
        acc_cnt  = 0;
      end
    end
  endtask

  // Offer one beat with a random gap before it; hold until accepted.
  task automatic send_beat(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_item  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_beat(it);
    n_sent++;
  endtask

  function automatic in_item_t load_item(input int idx, input int bits, input int len);
    in_item_t it;
    it = in_item_t'($urandom);
    it.cmd = CMD_LOAD;
    it.symbol_index = 8'(idx);
    it.code_bits = 16'(bits);
    it.code_length = 5'(len);
    return it;
  endfunction

  function automatic in_item_t data_item(input int byte_val, input bit blk);
    in_item_t it;
    it = in_item_t'({$urandom, $urandom});
    it.cmd = CMD_DATA;
    it.data_byte = 8'(byte_val);
    it.block_end = blk;
    return it;
  endfunction

  // Receiver: random stall, or a long hold-off when requested.
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else        out_stall <= hold_recv || ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_syms.size() == 0) begin
        report_mismatch("unexpected result", out_item.decoded_symbol, -1);
      end else begin
        out_item_t w;
        w = pending_syms.pop_front();
        if (out_item.decoded_symbol !== w.decoded_symbol)
          report_mismatch("decoded_symbol", out_item.decoded_symbol, w.decoded_symbol);
        if (out_item.code_error !== w.code_error)
          report_mismatch("code_error", out_item.code_error, w.code_error);
        if (out_item.last_of_byte !== w.last_of_byte)
          report_mismatch("last_of_byte", out_item.last_of_byte, w.last_of_byte);
        if (w.code_error) n_err_results++;
      end
      n_got++;
    end
  end

  // Drop valid and wait until every expected result has come.
  task automatic wait_drained();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (pending_syms.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
  endtask

  typedef struct {
    in_item_t   it;
    bit         typed;
    out_item_t  want;
  } dir_row_t;

  // Build a random prefix-free table: canonical codes with small random lengths.
  task automatic load_random_table(input int nsym, input int maxlen);
    int code;
    int len;
    int prev;
    code = 0;
    prev = 1;
    for (int s = 0; s < nsym; s++) begin
      len = prev + (($urandom_range(2) == 0 && prev < maxlen) ? 1 : 0);
      if (s == 0) len = 1;
      code = code << (len - prev);
      if (code >= (1 << len)) break;
      send_beat(load_item($urandom_range(255), code | ($urandom << len), len));
      code++;
      prev = len;
    end
  endtask

  dir_row_t rows [$];
  dir_row_t rw;

  initial begin
    errors = 0; n_sent = 0; n_got = 0; n_err_results = 0;
    send_idle_pct = 19; recv_idle_pct = 61; hold_recv = 0;
    in_valid = 1'b0; in_item = '0;
    for (int s = 0; s < NUM_SYMBOLS; s++) begin
      tbl_bits[s] = '0;
      tbl_len[s]  = '0;
    end
    acc_bits = '0; acc_cnt = 0;
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows. Empty table: 16 bits give one error on the second byte.
    rw.typed = 0; rw.want = '0;
    rw.it = data_item(8'h00, 0); rows.push_back(rw);
    rw.it = data_item(8'hFF, 0); rw.typed = 1; rw.want = '{8'd0, 1'b1, 1'b1};
    rows.push_back(rw);
    rw.typed = 0;
    rw.it = load_item(0, 16'hFFFE, 1);   rows.push_back(rw); // extra bits dropped: code 0
    rw.it = load_item(255, 16'hFFFF, 2); rows.push_back(rw); // code 11
    rw.it = load_item(7, 16'h0000, 1);   rows.push_back(rw); // duplicate of 0, 0 wins
    rw.it = load_item(9, 16'h1234, 17);  rows.push_back(rw); // over the limit: no code
    rw.it = load_item(10, 16'hFFFF, 16); rows.push_back(rw);
    rw.it = data_item(8'h00, 0); rows.push_back(rw);
    rw.it = data_item(8'hC0, 1); rows.push_back(rw);
    rw.it = data_item(8'h80, 1); rows.push_back(rw); // no match: leftover bits discarded
    rw.it = data_item(8'hFF, 0); rows.push_back(rw);
    rw.it = load_item(0, 0, 0);  rows.push_back(rw);
    rw.it = load_item(7, 0, 0);  rows.push_back(rw);
    rw.it = load_item(255, 0, 0); rows.push_back(rw);
    rw.it = data_item(8'hFF, 0); rows.push_back(rw);
    rw.it = data_item(8'hFF, 0); rows.push_back(rw); // 16 ones match symbol 10
    rw.it = data_item(8'h55, 1); rows.push_back(rw); // no result, block end
    rw.it = load_item(10, 0, 0); rows.push_back(rw);

    foreach (rows[i]) begin
      send_beat(rows[i].it);
      if (rows[i].typed && pending_syms.size() > 0) begin
        if (pending_syms[$] != rows[i].want)
          report_mismatch("directed row", int'(pending_syms[$]), int'(rows[i].want));
      end
    end
    wait_drained();
    repeat (300) @(posedge clk);

    // Random phases: new table, then streams with occasional noise.
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin send_idle_pct = 61; recv_idle_pct = 19; end
      if (ph == 2) begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      for (int s = 0; s < NUM_SYMBOLS; s++)
        if (tbl_len[s] != 0) send_beat(load_item(s, 0, 0));
      load_random_table($urandom_range(2, 12), (ph == 2) ? 16 : 6);
      for (int k = 0; k < 120; k++) begin
        case ($urandom_range(19))
          0:       send_beat(load_item($urandom_range(255), $urandom, $urandom_range(31)));
          1:       send_beat(data_item($urandom_range(255), 1));
          default: send_beat(data_item($urandom_range(255), $urandom_range(15) == 0));
        endcase
        if (ph == 0 && k == 40) begin
          // long receiver hold-off while the sender keeps going
          fork
            begin
              hold_recv = 1;
              repeat (6000) @(posedge clk);
              hold_recv = 0;
            end
          join_none
        end
        if (k == 80) wait_drained();
      end
      wait_drained();
      repeat (300) @(posedge clk);
    end

    wait_drained();
    repeat (300) @(posedge clk);
    if (pending_syms.size() != 0)
      report_mismatch("missing results", pending_syms.size(), 0);
    $display("covered %0d beats, %0d results (%0d code errors), three idle profiles",
             n_sent, n_got, n_err_results);
    if (errors == 0) $display("prefix_code_symbol_decoder_top_tb: PASS");
    else             $display("prefix_code_symbol_decoder_top_tb: FAIL");
    $finish;
  end

endmodule

// ===== prefix_code_symbol_decoder_top.f =====
hw/rtl/pcsd_pkg.sv
hw/rtl/pcsd_table.sv
hw/rtl/pcsd_core.sv
hw/rtl/prefix_code_symbol_decoder_top.sv
tb/sv/prefix_code_symbol_decoder_top_tb.sv
